[hw/rtl/spq_pkg.sv]
// Shared types and codes for the sorted priority queue.
// No dependencies; every other file of the block imports this package.
package spq_pkg;

	typedef enum logic [0:0] {
		OP_INSERT = 1'b0,
		OP_REMOVE = 1'b1
	} op_t;

	typedef enum logic [1:0] {
		ST_DONE  = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	localparam int unsigned DATA_W = 32;
	localparam int unsigned PRIO_W = 16;
	localparam int unsigned FILL_W = 5;

	typedef struct packed {
		logic signed [DATA_W-1:0] data;
		logic [PRIO_W-1:0]        prio;
	} entry_t;

	// Per-cell command: the shift direction for this cycle and whether the
	// cell currently holds a live entry.
	typedef struct packed {
		logic ins;
		logic rem;
		logic in_use;
	} cell_cmd_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] data;
		logic [PRIO_W-1:0]        prio;
		status_t                  status;
		logic [FILL_W-1:0]        fill;
	} result_t;

endpackage

[hw/rtl/sorted_priority_queue.sv]
// Sorted priority queue of CAPACITY entries built as a chain of cells kept in
// descending priority order, head first; among equal priorities the oldest
// sits nearest the head. Every cell compares its priority with an inserted
// beat's in parallel and all cells shift by one place together, so the queue
// takes one insert or remove per clock and its result beat is registered in
// a two-deep output buffer; input stalls only while that buffer is full. An
// insert into a full queue is dropped with a full status, a remove from an
// empty queue returns zeros with an empty status, and fill reports the entry
// count after the operation modulo 32.
module sorted_priority_queue #(
	parameter int unsigned CAPACITY = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        op,
	input  logic [31:0] item_data,
	input  logic [15:0] item_priority,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [31:0] taken_data,
	output logic [15:0] taken_priority,
	output logic [1:0]  status,
	output logic [4:0]  fill
);
	import spq_pkg::*;

	localparam int unsigned CNT_W = $clog2(CAPACITY + 1);

	logic [CNT_W-1:0] cnt_q;
	logic             accept;
	logic             is_remove;
	logic             q_full;
	logic             q_empty;
	logic             do_ins;
	logic             do_rem;
	logic             obuf_full;
	entry_t           new_entry;
	entry_t           cells [CAPACITY];
	logic             keeps [CAPACITY];
	result_t          res_next;
	result_t          res_out;

	assign in_stall  = obuf_full;
	assign accept    = in_valid && !obuf_full;
	assign is_remove = (op == OP_REMOVE);
	assign q_full    = (cnt_q == CNT_W'(CAPACITY));
	assign q_empty   = (cnt_q == '0);
	assign do_ins    = accept && !is_remove && !q_full;
	assign do_rem    = accept && is_remove && !q_empty;

	assign new_entry.data = item_data;
	assign new_entry.prio = item_priority;

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		cell_cmd_t cmd;
		entry_t    prev_e;
		entry_t    next_e;
		logic      prev_k;

		assign cmd.ins    = do_ins;
		assign cmd.rem    = do_rem;
		assign cmd.in_use = (CNT_W'(i) < cnt_q);

		if (i == 0) begin : g_head
			assign prev_e = new_entry;
			assign prev_k = 1'b1;
		end else begin : g_body
			assign prev_e = cells[i-1];
			assign prev_k = keeps[i-1];
		end

		if (i == CAPACITY - 1) begin : g_tail
			assign next_e = cells[i];
		end else begin : g_mid
			assign next_e = cells[i+1];
		end

		spq_cell u_cell (
			.clk        (clk),
			.cmd        (cmd),
			.prev_keep  (prev_k),
			.new_entry  (new_entry),
			.prev_entry (prev_e),
			.next_entry (next_e),
			.entry      (cells[i]),
			.keep       (keeps[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (do_ins) begin
			cnt_q <= cnt_q + CNT_W'(1);
		end else if (do_rem) begin
			cnt_q <= cnt_q - CNT_W'(1);
		end
	end

	always_comb begin
		res_next.data   = '0;
		res_next.prio   = '0;
		res_next.status = ST_DONE;
		res_next.fill   = FILL_W'(cnt_q);
		if (is_remove) begin
			if (q_empty) begin
				res_next.status = ST_EMPTY;
			end else begin
				res_next.data = cells[0].data;
				res_next.prio = cells[0].prio;
				res_next.fill = FILL_W'(cnt_q - CNT_W'(1));
			end
		end else if (q_full) begin
			res_next.status = ST_FULL;
		end else begin
			res_next.fill = FILL_W'(cnt_q + CNT_W'(1));
		end
	end

	spq_obuf u_obuf (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (accept),
		.res_in    (res_next),
		.full      (obuf_full),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.res_out   (res_out)
	);

	assign taken_data     = res_out.data;
	assign taken_priority = res_out.prio;
	assign status         = res_out.status;
	assign fill           = res_out.fill;

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(CAPACITY))
		else $error("entry count above capacity");

	a_head_order: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q >= CNT_W'(2)) |-> (cells[0].prio >= cells[1].prio))
		else $error("head cells out of priority order");

	a_skid_needs_out: assert property (@(posedge clk) disable iff (!arst_n)
		obuf_full |-> out_valid)
		else $error("skid register holds a beat while output is empty");

	a_empty_remove: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && is_remove && q_empty) |=> (cnt_q == '0))
		else $error("remove from empty queue changed the count");

endmodule

[hw/rtl/spq_cell.sv]
// One slot of the sorted chain: holds an entry and decides each cycle
// whether to keep it, take the new entry, or take a neighbor's entry.
// Depends on spq_pkg.
module spq_cell (
	input  logic               clk,
	input  spq_pkg::cell_cmd_t cmd,
	input  logic               prev_keep,
	input  spq_pkg::entry_t    new_entry,
	input  spq_pkg::entry_t    prev_entry,
	input  spq_pkg::entry_t    next_entry,
	output spq_pkg::entry_t    entry,
	output logic               keep
);
	import spq_pkg::*;

	entry_t entry_q;

	// A live entry whose priority is not below the new one stays in place,
	// so older equal entries stay nearer the head.
	assign keep  = cmd.in_use && (entry_q.prio >= new_entry.prio);
	assign entry = entry_q;

	always_ff @(posedge clk) begin
		if (cmd.ins) begin
			if (!keep) begin
				if (prev_keep) begin
					entry_q <= new_entry;
				end else begin
					entry_q <= prev_entry;
				end
			end
		end else if (cmd.rem) begin
			entry_q <= next_entry;
		end
	end

endmodule

[hw/rtl/spq_obuf.sv]
// Two-deep result buffer: an output register backed by a skid register,
// so a stalled consumer does not stall the input side combinationally.
// Depends on spq_pkg.
module spq_obuf (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  spq_pkg::result_t res_in,
	output logic             full,
	output logic             out_valid,
	input  logic             out_stall,
	output spq_pkg::result_t res_out
);
	import spq_pkg::*;

	result_t out_q;
	result_t skid_q;
	logic    out_valid_q;
	logic    skid_valid_q;
	logic    out_fire;

	assign out_fire  = out_valid_q && !out_stall;
	assign full      = skid_valid_q;
	assign out_valid = out_valid_q;
	assign res_out   = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else begin
			if (push) begin
				if (!out_valid_q || out_fire) begin
					out_valid_q <= 1'b1;
				end else begin
					skid_valid_q <= 1'b1;
				end
			end else if (out_fire) begin
				if (skid_valid_q) begin
					skid_valid_q <= 1'b0;
				end else begin
					out_valid_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			if (!out_valid_q || out_fire) begin
				out_q <= res_in;
			end else begin
				skid_q <= res_in;
			end
		end else if (out_fire && skid_valid_q) begin
			out_q <= skid_q;
		end
	end

endmodule
